// ===== design/owct_pkg.sv =====
// owct_pkg: shared types, codes and the microprogram of the 1-wire command sequencer
// used by owct_seq, owct_dp and one_wire_command_transaction_unit; no dependencies
package owct_pkg;

    localparam int MAX_READ    = 9;
    localparam int MAX_PAYLOAD = 3;
    localparam int ADDR_BYTES  = 8;

    localparam logic [7:0] SKIP_ROM  = 8'hCC;
    localparam logic [7:0] MATCH_ROM = 8'h55;

    localparam logic [1:0] PU_KEEP = 2'd0;
    localparam logic [1:0] PU_ON   = 2'd1;
    localparam logic [1:0] PU_OFF  = 2'd2;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_DONE   = 2'd1,
        OP_RXBYTE = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_MATCH    = 2'd0,
        CFG_SCAN     = 2'd1,
        CFG_DEVADDR  = 2'd2,
        CFG_PARASITE = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ACT_REFUSED  = 3'd0,
        ACT_RESET    = 3'd1,
        ACT_WRITE    = 3'd2,
        ACT_READREQ  = 3'd3,
        ACT_WAIT     = 3'd4,
        ACT_DATA     = 3'd5,
        ACT_FINISHED = 3'd6,
        ACT_IGNORED  = 3'd7
    } t_act;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RESET = 3'd1,
        PH_WRITE = 3'd2,
        PH_READ  = 3'd3,
        PH_WAIT  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        B_ZERO  = 3'd0,
        B_MATCH = 3'd1,
        B_SKIP  = 3'd2,
        B_ADDR  = 3'd3,
        B_CMD   = 3'd4,
        B_PAY   = 3'd5,
        B_RX    = 3'd6
    } t_bsel;

    typedef enum logic [1:0] {
        A_ZERO = 2'd0,
        A_RC   = 2'd1,
        A_HOLD = 2'd2
    } t_asel;

    typedef enum logic [2:0] {
        P_KEEP    = 3'd0,
        P_REL     = 3'd1,
        P_PAR_ON  = 3'd2,
        P_PAR_REL = 3'd3,
        P_CMD     = 3'd4
    } t_pusel;

    typedef enum logic [1:0] {
        L_ZERO  = 2'd0,
        L_ONE   = 2'd1,
        L_COND  = 2'd2,
        L_NCOND = 2'd3
    } t_lsel;

    localparam int COND_N = 19;
    typedef enum logic [4:0] {
        C_NEVER     = 5'd0,
        C_ALWAYS    = 5'd1,
        C_OP_START  = 5'd2,
        C_OP_DONE   = 5'd3,
        C_RX_OK     = 5'd4,
        C_REFUSE    = 5'd5,
        C_PH_RESET  = 5'd6,
        C_PH_WRITE  = 5'd7,
        C_PH_READ   = 5'd8,
        C_PH_WAIT   = 5'd9,
        C_NO_PRES   = 5'd10,
        C_NO_PFX    = 5'd11,
        C_SKIP      = 5'd12,
        C_ADDR_MORE = 5'd13,
        C_PC_ZERO   = 5'd14,
        C_PAY_MORE  = 5'd15,
        C_RC_NZ     = 5'd16,
        C_HOLD_NZ   = 5'd17,
        C_RD_MORE   = 5'd18
    } t_cond;

    typedef struct packed {
        logic   wait_in;
        logic   emit;
        t_act   act;
        t_bsel  bsel;
        t_asel  asel;
        t_pusel pusel;
        logic   ok;
        t_lsel  lsel;
        t_cond  cond;
        t_upc   target;
        logic   phase_wr;
        t_phase phase;
        logic   save;
        logic   fill_clr;
        logic   rx_wr;
        logic   cnt_clr;
        logic   cnt_inc;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_uword uw;
        logic   go;
        logic   take;
        logic   hit;
    } t_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic [COND_N-1:0] cond;
        logic              slot_free;
    } t_stat;

    // program entry points
    localparam t_upc S_IDLE   = 5'd0;
    localparam t_upc S_START  = 5'd5;
    localparam t_upc S_START2 = 5'd6;
    localparam t_upc S_RXST   = 5'd7;
    localparam t_upc S_DONE   = 5'd8;
    localparam t_upc S_RST    = 5'd13;
    localparam t_upc S_MATCH  = 5'd16;
    localparam t_upc S_ADDR   = 5'd17;
    localparam t_upc S_CMD    = 5'd18;
    localparam t_upc S_PAY    = 5'd19;
    localparam t_upc S_WR     = 5'd21;
    localparam t_upc S_RD     = 5'd24;
    localparam t_upc S_WT     = 5'd26;
    localparam t_upc S_REF    = 5'd27;
    localparam t_upc S_NOPRES = 5'd28;
    localparam t_upc S_SKIPB  = 5'd29;
    localparam t_upc S_RDREQ  = 5'd30;
    localparam t_upc S_WTST   = 5'd31;

    function automatic t_uword ucode(input t_upc a);
        t_uword uw;
        uw = '0;
        case (a)
            5'd0: begin
                uw.wait_in = 1'b1; uw.cnt_clr = 1'b1; uw.cond = C_NEVER;
            end
            5'd1: begin uw.cond = C_OP_START; uw.target = S_START; end
            5'd2: begin uw.cond = C_OP_DONE;  uw.target = S_DONE;  end
            5'd3: begin uw.cond = C_RX_OK;    uw.target = S_RXST;  end
            5'd4: begin
                uw.emit = 1'b1; uw.act = ACT_IGNORED; uw.lsel = L_ONE;
                uw.cond = C_ALWAYS; uw.target = S_IDLE;
            end
            5'd5: begin uw.cond = C_REFUSE; uw.target = S_REF; end
            5'd6: begin
                uw.emit = 1'b1; uw.act = ACT_RESET; uw.pusel = P_REL; uw.lsel = L_ONE;
                uw.save = 1'b1; uw.fill_clr = 1'b1;
                uw.phase_wr = 1'b1; uw.phase = PH_RESET;
                uw.cond = C_ALWAYS; uw.target = S_IDLE;
            end
            5'd7: begin uw.rx_wr = 1'b1; uw.cond = C_ALWAYS; uw.target = S_IDLE; end
            5'd8:  begin uw.cond = C_PH_RESET; uw.target = S_RST; end
            5'd9:  begin uw.cond = C_PH_WRITE; uw.target = S_WR;  end
            5'd10: begin uw.cond = C_PH_READ;  uw.target = S_RD;  end
            5'd11: begin uw.cond = C_PH_WAIT;  uw.target = S_WT;  end
            5'd12: begin
                uw.emit = 1'b1; uw.act = ACT_IGNORED; uw.lsel = L_ONE;
                uw.cond = C_ALWAYS; uw.target = S_IDLE;
            end
            5'd13: begin uw.cond = C_NO_PRES; uw.target = S_NOPRES; end
            5'd14: begin uw.cond = C_NO_PFX;  uw.target = S_CMD;    end
            5'd15: begin uw.cond = C_SKIP;    uw.target = S_SKIPB;  end
            5'd16: begin
                uw.emit = 1'b1; uw.act = ACT_WRITE; uw.bsel = B_MATCH; uw.pusel = P_PAR_ON;
                uw.cond = C_NEVER;
            end
            5'd17: begin
                uw.emit = 1'b1; uw.act = ACT_WRITE; uw.bsel = B_ADDR; uw.cnt_inc = 1'b1;
                uw.cond = C_ADDR_MORE; uw.target = S_ADDR;
            end
            5'd18: begin
                uw.emit = 1'b1; uw.act = ACT_WRITE; uw.bsel = B_CMD; uw.pusel = P_CMD;
                uw.lsel = L_COND; uw.cnt_clr = 1'b1;
                uw.phase_wr = 1'b1; uw.phase = PH_WRITE;
                uw.cond = C_PC_ZERO; uw.target = S_IDLE;
            end
            5'd19: begin
                uw.emit = 1'b1; uw.act = ACT_WRITE; uw.bsel = B_PAY; uw.cnt_inc = 1'b1;
                uw.lsel = L_NCOND; uw.cond = C_PAY_MORE; uw.target = S_PAY;
            end
            5'd20: begin uw.cond = C_ALWAYS; uw.target = S_IDLE; end
            5'd21: begin uw.cond = C_RC_NZ;   uw.target = S_RDREQ; end
            5'd22: begin uw.cond = C_HOLD_NZ; uw.target = S_WTST;  end
            5'd23: begin
                uw.emit = 1'b1; uw.act = ACT_FINISHED; uw.pusel = P_PAR_REL; uw.ok = 1'b1;
                uw.lsel = L_ONE; uw.phase_wr = 1'b1; uw.phase = PH_IDLE;
                uw.cond = C_ALWAYS; uw.target = S_IDLE;
            end
            5'd24: begin
                uw.emit = 1'b1; uw.act = ACT_DATA; uw.bsel = B_RX; uw.cnt_inc = 1'b1;
                uw.cond = C_RD_MORE; uw.target = S_RD;
            end
            5'd25: begin
                uw.emit = 1'b1; uw.act = ACT_FINISHED; uw.ok = 1'b1; uw.lsel = L_ONE;
                uw.phase_wr = 1'b1; uw.phase = PH_IDLE;
                uw.cond = C_ALWAYS; uw.target = S_IDLE;
            end
            5'd26: begin
                uw.emit = 1'b1; uw.act = ACT_FINISHED; uw.pusel = P_REL; uw.ok = 1'b1;
                uw.lsel = L_ONE; uw.phase_wr = 1'b1; uw.phase = PH_IDLE;
                uw.cond = C_ALWAYS; uw.target = S_IDLE;
            end
            5'd27: begin
                uw.emit = 1'b1; uw.act = ACT_REFUSED; uw.lsel = L_ONE;
                uw.cond = C_ALWAYS; uw.target = S_IDLE;
            end
            5'd28: begin
                uw.emit = 1'b1; uw.act = ACT_FINISHED; uw.lsel = L_ONE;
                uw.phase_wr = 1'b1; uw.phase = PH_IDLE;
                uw.cond = C_ALWAYS; uw.target = S_IDLE;
            end
            5'd29: begin
                uw.emit = 1'b1; uw.act = ACT_WRITE; uw.bsel = B_SKIP; uw.pusel = P_PAR_ON;
                uw.cond = C_ALWAYS; uw.target = S_CMD;
            end
            5'd30: begin
                uw.emit = 1'b1; uw.act = ACT_READREQ; uw.asel = A_RC; uw.pusel = P_PAR_REL;
                uw.lsel = L_ONE; uw.fill_clr = 1'b1;
                uw.phase_wr = 1'b1; uw.phase = PH_READ;
                uw.cond = C_ALWAYS; uw.target = S_IDLE;
            end
            5'd31: begin
                uw.emit = 1'b1; uw.act = ACT_WAIT; uw.asel = A_HOLD; uw.pusel = P_PAR_ON;
                uw.lsel = L_ONE; uw.phase_wr = 1'b1; uw.phase = PH_WAIT;
                uw.cond = C_ALWAYS; uw.target = S_IDLE;
            end
            default: begin uw.cond = C_ALWAYS; uw.target = S_IDLE; end
        endcase
        return uw;
    endfunction

endpackage

// ===== design/owct_seq.sv =====
// owct_seq: step counter and control store of the command sequencer
// depends on owct_pkg (control word layout and microprogram)
module owct_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  owct_pkg::t_stat  i_stat,
    output owct_pkg::t_ctl   o_ctl
);

    owct_pkg::t_upc   r_upc;
    owct_pkg::t_upc   n_upc;
    owct_pkg::t_uword w_uw;
    logic             w_hit;
    logic             w_go;

    always_comb begin
        w_uw  = owct_pkg::ucode(r_upc);
        w_hit = i_stat.cond[w_uw.cond];
        // an emitting step waits for room in the output register
        if (w_uw.wait_in) begin
            w_go = i_in_valid;
        end else begin
            w_go = ~w_uw.emit | i_stat.slot_free;
        end
        if (!w_go) begin
            n_upc = r_upc;
        end else if (w_hit) begin
            n_upc = w_uw.target;
        end else begin
            n_upc = r_upc + owct_pkg::t_upc'(1);
        end
        o_ctl.uw   = w_uw;
        o_ctl.go   = w_go;
        o_ctl.take = w_uw.wait_in & i_in_valid;
        o_ctl.hit  = w_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= owct_pkg::S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== design/owct_dp.sv =====
// owct_dp: datapath of the command sequencer: item latch, saved arguments,
// config registers, read byte store, loop counter and output register; uses owct_pkg
module owct_dp #(
    parameter int MAX_READ = owct_pkg::MAX_READ
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  owct_pkg::t_ctl   i_ctl,
    output owct_pkg::t_stat  o_stat,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_wdata,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_cmd_byte,
    input  logic [23:0]      i_payload_bytes,
    input  logic [1:0]       i_payload_count,
    input  logic [3:0]       i_read_count,
    input  logic [15:0]      i_hold_time,
    input  logic             i_no_prefix,
    input  logic             i_owner_busy,
    input  logic             i_presence_seen,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [2:0]       o_action,
    output logic [7:0]       o_byte_value,
    output logic [15:0]      o_amount,
    output logic [1:0]       o_pullup_cmd,
    output logic             o_success,
    output logic             o_last
);

    localparam int RC_W  = $clog2(MAX_READ + 1);
    localparam int IDX_W = (MAX_READ > 1) ? $clog2(MAX_READ) : 1;
    localparam int CNT_MAX = (MAX_READ > owct_pkg::ADDR_BYTES) ? MAX_READ
                                                               : owct_pkg::ADDR_BYTES;
    localparam int CNT_W = $clog2(CNT_MAX);

    // latched input beat
    owct_pkg::t_op    r_in_op;
    logic [7:0]       r_in_cmd;
    logic [23:0]      r_in_pay;
    logic [1:0]       r_in_pc;
    logic [3:0]       r_in_rc;
    logic [15:0]      r_in_hold;
    logic             r_in_nopfx;
    logic             r_in_busy;
    logic             r_in_pres;
    logic [7:0]       r_in_rx;

    // saved transaction arguments
    logic [7:0]       r_cmd;
    logic [23:0]      r_pay;
    logic [1:0]       r_pc;
    logic [RC_W-1:0]  r_rc;
    logic [15:0]      r_hold;
    logic             r_nopfx;

    // configuration
    logic             r_match;
    logic             r_scan;
    logic [63:0]      r_dev;
    logic             r_par;

    owct_pkg::t_phase r_phase;
    logic [RC_W-1:0]  r_fill;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_rx [MAX_READ];

    logic             r_out_valid;
    logic [2:0]       r_action;
    logic [7:0]       r_byte;
    logic [15:0]      r_amount;
    logic [1:0]       r_pullup;
    logic             r_success;
    logic             r_last;

    owct_pkg::t_uword         w_uw;
    logic                     w_step;
    logic                     w_load;
    logic [CNT_W:0]           w_cnt1;
    logic [owct_pkg::COND_N-1:0] w_cond;
    logic [7:0]               w_pay_byte;
    logic [7:0]               w_rx_byte;
    logic [7:0]               w_byte;
    logic [15:0]              w_amount;
    logic [1:0]               w_pullup;
    logic                     w_last;

    assign w_uw   = i_ctl.uw;
    assign w_step = i_ctl.go & ~w_uw.wait_in;
    assign w_load = w_step & w_uw.emit;
    assign w_cnt1 = {1'b0, r_cnt} + (CNT_W + 1)'(1);

    always_comb begin
        w_cond = '0;
        w_cond[owct_pkg::C_ALWAYS]    = 1'b1;
        w_cond[owct_pkg::C_OP_START]  = (r_in_op == owct_pkg::OP_START);
        w_cond[owct_pkg::C_OP_DONE]   = (r_in_op == owct_pkg::OP_DONE);
        w_cond[owct_pkg::C_RX_OK]     = (r_in_op == owct_pkg::OP_RXBYTE)
                                      && (r_phase == owct_pkg::PH_READ) && (r_fill < r_rc);
        w_cond[owct_pkg::C_REFUSE]    = r_in_busy || (r_phase != owct_pkg::PH_IDLE);
        w_cond[owct_pkg::C_PH_RESET]  = (r_phase == owct_pkg::PH_RESET);
        w_cond[owct_pkg::C_PH_WRITE]  = (r_phase == owct_pkg::PH_WRITE);
        w_cond[owct_pkg::C_PH_READ]   = (r_phase == owct_pkg::PH_READ);
        w_cond[owct_pkg::C_PH_WAIT]   = (r_phase == owct_pkg::PH_WAIT);
        w_cond[owct_pkg::C_NO_PRES]   = ~r_in_pres;
        w_cond[owct_pkg::C_NO_PFX]    = r_nopfx;
        w_cond[owct_pkg::C_SKIP]      = ~(r_match & ~r_scan);
        w_cond[owct_pkg::C_ADDR_MORE] = 32'(w_cnt1) < owct_pkg::ADDR_BYTES;
        w_cond[owct_pkg::C_PC_ZERO]   = (r_pc == 2'd0);
        w_cond[owct_pkg::C_PAY_MORE]  = 32'(w_cnt1) < 32'(r_pc);
        w_cond[owct_pkg::C_RC_NZ]     = (r_rc != '0);
        w_cond[owct_pkg::C_HOLD_NZ]   = (r_hold != 16'd0);
        w_cond[owct_pkg::C_RD_MORE]   = 32'(w_cnt1) < 32'(r_rc);
    end

    assign o_stat.cond      = w_cond;
    assign o_stat.slot_free = ~r_out_valid | ~i_out_stall;

    // byte sources
    always_comb begin
        if (32'(r_cnt) < 3) begin
            case (r_cnt[1:0])
                2'd0:    w_pay_byte = r_pay[7:0];
                2'd1:    w_pay_byte = r_pay[15:8];
                2'd2:    w_pay_byte = r_pay[23:16];
                default: w_pay_byte = 8'd0;
            endcase
        end else begin
            w_pay_byte = 8'd0;
        end
        // a byte that did not arrive reads as zero
        if (32'(r_cnt) < 32'(r_fill)) begin
            w_rx_byte = r_rx[r_cnt[IDX_W-1:0]];
        end else begin
            w_rx_byte = 8'd0;
        end
    end

    always_comb begin
        case (w_uw.bsel)
            owct_pkg::B_MATCH: w_byte = owct_pkg::MATCH_ROM;
            owct_pkg::B_SKIP:  w_byte = owct_pkg::SKIP_ROM;
            owct_pkg::B_ADDR:  w_byte = r_dev[{r_cnt[2:0], 3'b000} +: 8];
            owct_pkg::B_CMD:   w_byte = r_cmd;
            owct_pkg::B_PAY:   w_byte = w_pay_byte;
            owct_pkg::B_RX:    w_byte = w_rx_byte;
            default:           w_byte = 8'd0;
        endcase
        case (w_uw.asel)
            owct_pkg::A_RC:   w_amount = 16'(r_rc);
            owct_pkg::A_HOLD: w_amount = r_hold;
            default:          w_amount = 16'd0;
        endcase
        case (w_uw.pusel)
            owct_pkg::P_REL:     w_pullup = owct_pkg::PU_OFF;
            owct_pkg::P_PAR_ON:  w_pullup = r_par ? owct_pkg::PU_ON : owct_pkg::PU_KEEP;
            owct_pkg::P_PAR_REL: w_pullup = r_par ? owct_pkg::PU_OFF : owct_pkg::PU_KEEP;
            owct_pkg::P_CMD:     w_pullup = (r_par && r_nopfx) ? owct_pkg::PU_ON
                                                               : owct_pkg::PU_KEEP;
            default:             w_pullup = owct_pkg::PU_KEEP;
        endcase
        case (w_uw.lsel)
            owct_pkg::L_ONE:   w_last = 1'b1;
            owct_pkg::L_COND:  w_last = i_ctl.hit;
            owct_pkg::L_NCOND: w_last = ~i_ctl.hit;
            default:           w_last = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= owct_pkg::PH_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_match     <= 1'b0;
            r_scan      <= 1'b0;
            r_dev       <= 64'd0;
            r_par       <= 1'b0;
        end else begin
            if (w_step && w_uw.phase_wr) begin
                r_phase <= w_uw.phase;
            end
            if (w_step && w_uw.fill_clr) begin
                r_fill <= '0;
            end else if (w_step && w_uw.rx_wr) begin
                r_fill <= r_fill + RC_W'(1);
            end
            if (i_ctl.go && w_uw.cnt_clr) begin
                r_cnt <= '0;
            end else if (w_step && w_uw.cnt_inc) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (owct_pkg::t_cfg_reg'(i_cfg_index))
                    owct_pkg::CFG_MATCH:    r_match <= i_cfg_wdata[0];
                    owct_pkg::CFG_SCAN:     r_scan  <= i_cfg_wdata[0];
                    owct_pkg::CFG_DEVADDR:  r_dev   <= i_cfg_wdata;
                    owct_pkg::CFG_PARASITE: r_par   <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_in_op    <= owct_pkg::t_op'(i_opcode);
            r_in_cmd   <= i_cmd_byte;
            r_in_pay   <= i_payload_bytes;
            r_in_pc    <= i_payload_count;
            r_in_rc    <= i_read_count;
            r_in_hold  <= i_hold_time;
            r_in_nopfx <= i_no_prefix;
            r_in_busy  <= i_owner_busy;
            r_in_pres  <= i_presence_seen;
            r_in_rx    <= i_rx_byte;
        end
        if (w_step && w_uw.save) begin
            r_cmd   <= r_in_cmd;
            r_pay   <= r_in_pay;
            r_pc    <= (32'(r_in_pc) > owct_pkg::MAX_PAYLOAD) ? 2'(owct_pkg::MAX_PAYLOAD)
                                                              : r_in_pc;
            r_rc    <= (32'(r_in_rc) > MAX_READ) ? RC_W'(MAX_READ) : RC_W'(r_in_rc);
            r_hold  <= r_in_hold;
            r_nopfx <= r_in_nopfx;
        end
        if (w_step && w_uw.rx_wr) begin
            r_rx[r_fill[IDX_W-1:0]] <= r_in_rx;
        end
        if (w_load) begin
            r_action  <= 3'(w_uw.act);
            r_byte    <= w_byte;
            r_amount  <= w_amount;
            r_pullup  <= w_pullup;
            r_success <= w_uw.ok;
            r_last    <= w_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_action     = r_action;
    assign o_byte_value = r_byte;
    assign o_amount     = r_amount;
    assign o_pullup_cmd = r_pullup;
    assign o_success    = r_success;
    assign o_last       = r_last;

endmodule

// ===== design/one_wire_command_transaction_unit.sv =====
// one_wire_command_transaction_unit: microcoded 1-wire command transaction sequencer.
// The first result of an accepted beat, if it has one, follows its dispatch steps; the next
// beat can be taken after those steps and one step per byte, later while stalled.
// One item at a time; the results of one beat leave on consecutive cycles unless stalled.
// Reset (synchronous, active low): step counter to entry, phase idle, config zero,
// output empty; the read byte store is not cleared.
module one_wire_command_transaction_unit #(
    parameter int MAX_READ = owct_pkg::MAX_READ
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_cmd_byte,
    input  logic [23:0] i_payload_bytes,
    input  logic [1:0]  i_payload_count,
    input  logic [3:0]  i_read_count,
    input  logic [15:0] i_hold_time,
    input  logic        i_no_prefix,
    input  logic        i_owner_busy,
    input  logic        i_presence_seen,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_action,
    output logic [7:0]  o_byte_value,
    output logic [15:0] o_amount,
    output logic [1:0]  o_pullup_cmd,
    output logic        o_success,
    output logic        o_last
);

    owct_pkg::t_ctl  w_ctl;
    owct_pkg::t_stat w_stat;

    owct_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    owct_dp #(
        .MAX_READ (MAX_READ)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_stat          (w_stat),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_opcode),
        .i_cmd_byte      (i_cmd_byte),
        .i_payload_bytes (i_payload_bytes),
        .i_payload_count (i_payload_count),
        .i_read_count    (i_read_count),
        .i_hold_time     (i_hold_time),
        .i_no_prefix     (i_no_prefix),
        .i_owner_busy    (i_owner_busy),
        .i_presence_seen (i_presence_seen),
        .i_rx_byte       (i_rx_byte),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_action        (o_action),
        .o_byte_value    (o_byte_value),
        .o_amount        (o_amount),
        .o_pullup_cmd    (o_pullup_cmd),
        .o_success       (o_success),
        .o_last          (o_last)
    );

    assign o_in_stall = ~w_ctl.uw.wait_in;

    // a finished beat always closes the results of its input beat
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action == 3'(owct_pkg::ACT_FINISHED)) |-> o_last)
        else $error("finished beat without last");

    // success flag only rides on a finished beat
    a_success_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_success |-> (o_action == 3'(owct_pkg::ACT_FINISHED)))
        else $error("success outside finished beat");

    // after taking a beat the sequencer is busy with it
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken before dispatch");

    // a refused start never drives the pull-up
    a_refuse_pu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action == 3'(owct_pkg::ACT_REFUSED))
            |-> (o_pullup_cmd == owct_pkg::PU_KEEP) && o_last)
        else $error("refused beat with pull-up or not last");

endmodule
